### rtl/clf_pkg.sv
package clf_pkg;

    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_DEC    = 3'd1;
    localparam logic [2:0] KIND_HEX    = 3'd2;
    localparam logic [2:0] KIND_BIN    = 3'd3;
    localparam logic [2:0] KIND_CURSOR = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_INIT   = 3'd6;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    localparam int DIG_N = 10;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_A     = 8'h41;

    localparam logic [7:0] CMD_HOME4   = 8'h02;
    localparam logic [7:0] CMD_FUNC4   = 8'h28;
    localparam logic [7:0] CMD_FUNC8   = 8'h38;
    localparam logic [7:0] CMD_DISP_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_SUB,
        S_EMIT
    } state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib <= 4'd9)
            res = CHAR_ZERO + {4'd0, nib};
        else
            res = CHAR_A + {4'd0, nib} - 8'd10;
        return res;
    endfunction

    function automatic logic [7:0] init_byte(input logic four_bit, input logic [2:0] idx);
        logic [7:0] res;
        res = CMD_ENTRY;
        if (four_bit)
        begin
            case (idx)
                3'd0:    res = CMD_HOME4;
                3'd1:    res = CMD_FUNC4;
                3'd2:    res = CMD_DISP_ON;
                3'd3:    res = CMD_CLEAR;
                default: res = CMD_ENTRY;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    res = CMD_FUNC8;
                3'd1:    res = CMD_DISP_ON;
                3'd2:    res = CMD_CLEAR;
                default: res = CMD_ENTRY;
            endcase
        end
        return res;
    endfunction

endpackage

### rtl/clf_div10.sv
module clf_div10
    import clf_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] dividend,
    output logic [31:0] quotient,
    output logic [3:0]  remainder
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [31:0] x_reg;
    logic [31:0] diff;

    // reciprocal multiply, exact for every 32-bit dividend
    assign prod_next = 64'(dividend) * 64'(DIV10_RECIP);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= dividend;
    end

    assign quotient  = 32'(prod_reg[63:DIV10_SHIFT]);
    assign diff      = x_reg - ((quotient << 3) + (quotient << 1));
    assign remainder = diff[3:0];

endmodule

### rtl/char_lcd_value_formatter.sv
// Character-LCD formatter: each request transfer becomes a run of controller
// writes on the output channel, one byte per transfer, is_data marking data
// against command and last marking the final write of the request. A request
// is taken only while the block is idle. Char, cursor and clear give one write,
// hex two, binary up to eight, init four or five (bus_mode selects), each
// write going out as soon as the output is not stalled. Decimal runs a
// divide-by-ten unit (registered reciprocal multiply, then a subtract) once
// per digit, up to ten digits, before its up to eleven writes start.
// Kind 7 is dropped with no writes. bus_mode is always ready and resets to 1.
module char_lcd_value_formatter
    import clf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    input  logic               row,
    input  logic [5:0]         column,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_data,
    output logic [7:0]         out_byte,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               bus_mode
);

    state_t      state_reg, state_next;
    logic        bus_mode_reg;
    logic [2:0]  kind_reg, kind_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic [3:0]  dig_reg  [DIG_N];
    logic [3:0]  dig_next [DIG_N];
    logic [3:0]  ndig_reg, ndig_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  bits_reg, bits_next;
    logic [7:0]  byte_reg, byte_next;

    logic        out_valid_reg, out_valid_next;
    logic        is_data_reg, is_data_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;

    logic [31:0] div_q;
    logic [3:0]  div_r;
    logic [7:0]  low8;
    logic [3:0]  lz;
    logic        out_free;

    clf_div10 u_div10 (
        .clk       (clk),
        .dividend  (mag_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign low8      = value[7:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        lz = 4'd8;
        for (int b = 0; b < 8; b++)
        begin
            if (low8[b])
                lz = 4'(7 - b);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        ndig_next      = ndig_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        bits_next      = bits_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_data_next   = is_data_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        for (int i = 0; i < DIG_N; i++)
            dig_next[i] = dig_reg[i];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    idx_next   = 3'd0;
                    cnt_next   = 4'd1;
                    byte_next  = low8;
                    state_next = S_EMIT;
                    case (kind)
                        KIND_CHAR:   byte_next = low8;
                        KIND_DEC:
                        begin
                            neg_next   = value[31];
                            mag_next   = value[31] ? (32'd0 - value) : value;
                            ndig_next  = 4'd0;
                            state_next = S_DIV_MUL;
                        end
                        KIND_HEX:
                        begin
                            dig_next[0] = low8[7:4];
                            dig_next[1] = low8[3:0];
                            cnt_next    = 4'd2;
                        end
                        KIND_BIN:
                        begin
                            bits_next = low8 << lz;
                            cnt_next  = (low8 == 8'd0) ? 4'd1 : (4'd8 - lz);
                        end
                        KIND_CURSOR: byte_next = {1'b1, row, column};
                        KIND_CLEAR:  byte_next = CMD_CLEAR;
                        KIND_INIT:   cnt_next  = bus_mode_reg ? 4'd5 : 4'd4;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end

            S_DIV_MUL:
            begin
                state_next = S_DIV_SUB;
            end

            S_DIV_SUB:
            begin
                dig_next[0] = div_r;
                for (int i = 1; i < DIG_N; i++)
                    dig_next[i] = dig_reg[i-1];
                ndig_next = ndig_reg + 4'd1;
                mag_next  = div_q;
                if (div_q == 32'd0 || ndig_next == 4'(DIG_N))
                begin
                    cnt_next   = ndig_next + {3'd0, neg_reg};
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV_MUL;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = (cnt_reg == 4'd1);
                    cnt_next       = cnt_reg - 4'd1;
                    idx_next       = idx_reg + 3'd1;
                    is_data_next   = 1'b1;
                    case (kind_reg)
                        KIND_DEC:
                        begin
                            if (neg_reg)
                            begin
                                out_byte_next = CHAR_MINUS;
                                neg_next      = 1'b0;
                            end
                            else
                            begin
                                out_byte_next = CHAR_ZERO + {4'd0, dig_reg[0]};
                                for (int i = 0; i < DIG_N - 1; i++)
                                    dig_next[i] = dig_reg[i+1];
                                dig_next[DIG_N-1] = 4'd0;
                            end
                        end
                        KIND_HEX:
                        begin
                            out_byte_next = hex_char(dig_reg[0]);
                            for (int i = 0; i < DIG_N - 1; i++)
                                dig_next[i] = dig_reg[i+1];
                            dig_next[DIG_N-1] = 4'd0;
                        end
                        KIND_BIN:
                        begin
                            out_byte_next = bits_reg[7] ? CHAR_ONE : CHAR_ZERO;
                            bits_next     = {bits_reg[6:0], 1'b0};
                        end
                        KIND_INIT:
                        begin
                            out_byte_next = init_byte(bus_mode_reg, idx_reg);
                            is_data_next  = 1'b0;
                        end
                        KIND_CHAR:
                        begin
                            out_byte_next = byte_reg;
                        end
                        default:
                        begin
                            out_byte_next = byte_reg;
                            is_data_next  = 1'b0;
                        end
                    endcase
                    if (cnt_reg == 4'd1)
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bus_mode_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            ndig_reg      <= 4'd0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            ndig_reg      <= ndig_next;
            neg_reg       <= neg_next;
            if (cfg_valid)
                bus_mode_reg <= bus_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        mag_reg      <= mag_next;
        idx_reg      <= idx_next;
        bits_reg     <= bits_next;
        byte_reg     <= byte_next;
        is_data_reg  <= is_data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        for (int i = 0; i < DIG_N; i++)
            dig_reg[i] <= dig_next[i];
    end

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind != KIND_NONE) |=> state_reg != S_IDLE)
        else $error("request transfer did not start a sequence");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (cnt_reg != 4'd0 && cnt_reg <= 4'd11))
        else $error("write count out of range while emitting");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_SUB) |-> (div_r <= 4'd9 && ndig_reg < 4'(DIG_N)))
        else $error("divide-by-ten step out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && cnt_reg == 4'd1) |=>
            (state_reg == S_IDLE && last_reg && out_valid_reg))
        else $error("final write not marked last");
`endif

endmodule
